/* hw/rtl/assert_macros.svh */
// Assertion helpers for the sampler RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/fmbs_pkg.sv */
package fmbs_pkg;

   localparam int MAX_CHANNELS  = 32;
   localparam int MAX_HEIGHT    = 64;
   localparam int MAX_WIDTH     = 64;
   localparam int FRACTION_BITS = 8;

   localparam int ONE_FIX = 1 << FRACTION_BITS;

   // Signed coordinate width: holds a floored position plus one and any bound
   localparam int COORD_BITS = 14;

   localparam int CH_BITS   = 5;
   localparam int ROW_BITS  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ADDR_BITS = CH_BITS + ROW_BITS + COL_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;

   localparam int WEIGHT_BITS = 2 * FRACTION_BITS + 2;
   localparam int PROD_BITS   = 16 + WEIGHT_BITS + 1;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_CHANNELS = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_WIDTH    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

endpackage

/* hw/rtl/feature_map_bilinear_sampler.sv */
// Bilinear sampler over a multi-channel feature map held in one on-chip RAM.
// A write command (req_op = 0) is taken at once and gives no result;
// busy stays low and the next command may follow at once. A sample command
// (req_op = 1) raises busy and strobes rsp_valid with the exact
// weighted sum in the cycle that busy falls; a new command may be started in
// that same cycle. Busy is held by the single RAM read port: the four
// taps are read one per cycle, then one multiply stage and one accumulate
// stage. Taps outside the configured map or channel range count as zero.
// Results cannot be held off: capture rsp_sample_value whenever rsp_valid is
// high. Size registers may only be written while busy is low.
`include "assert_macros.svh"

module feature_map_bilinear_sampler
   import fmbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [4:0]         req_channel,
   input  logic [5:0]         req_write_row,
   input  logic [5:0]         req_write_col,
   input  logic signed [15:0] req_write_value,
   input  logic signed [15:0] req_sample_x,
   input  logic signed [15:0] req_sample_y,

   output logic               rsp_valid,
   output logic signed [31:0] rsp_sample_value,

   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_wdata
);

   // Feature RAM
   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [ADDR_BITS-1:0] wr_addr;
   logic                 wr_en;

   // Control state
   state_type state_ff, state_in;
   logic [1:0] tap_ff, tap_in;
   logic       issue_vld_ff, issue_vld_in;
   logic       issue_last_ff, issue_last_in;
   logic       prod_vld_ff, prod_vld_in;
   logic       prod_last_ff, prod_last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [5:0] channels_ff, channels_in;
   logic [6:0] height_ff, height_in;
   logic [6:0] width_ff, width_in;

   // Payload
   logic [4:0]                    ch_ff, ch_in;
   logic signed [COORD_BITS-1:0]  x0_ff, x0_in;
   logic signed [COORD_BITS-1:0]  y0_ff, y0_in;
   logic [FRACTION_BITS-1:0]      fx_ff, fx_in;
   logic [FRACTION_BITS-1:0]      fy_ff, fy_in;
   logic [WEIGHT_BITS-1:0]        weight_ff, weight_in;
   logic                          hit_ff, hit_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [31:0]            acc_ff, acc_in;
   logic signed [31:0]            rsp_value_ff, rsp_value_in;

   logic                          accept;
   logic signed [COORD_BITS-1:0]  row_t;
   logic signed [COORD_BITS-1:0]  col_t;
   logic signed [COORD_BITS-1:0]  w_row;
   logic signed [COORD_BITS-1:0]  w_col;
   logic [FRACTION_BITS:0]        wx;
   logic [FRACTION_BITS:0]        wy;
   logic signed [31:0]            acc_sum;

   function automatic logic in_bound(input logic signed [COORD_BITS-1:0] c,
                                     input logic [6:0] lim, input int max_lim);
      logic [COORD_BITS-1:0] cu;
      cu = $unsigned(c);
      return !c[COORD_BITS-1] && (cu < COORD_BITS'(lim)) && (cu < COORD_BITS'(max_lim));
   endfunction

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign w_row = COORD_BITS'(req_write_row);
   assign w_col = COORD_BITS'(req_write_col);
   assign wr_en = accept && (req_op == OP_WRITE)
                  && (COORD_BITS'(req_channel) < COORD_BITS'(channels_ff))
                  && (COORD_BITS'(req_channel) < COORD_BITS'(MAX_CHANNELS))
                  && in_bound(w_row, height_ff, MAX_HEIGHT)
                  && in_bound(w_col, width_ff, MAX_WIDTH);
   assign wr_addr = {req_channel, w_row[ROW_BITS-1:0], w_col[COL_BITS-1:0]};

   // Tap k: bit 0 steps the column, bit 1 steps the row
   assign col_t   = x0_ff + $signed({{(COORD_BITS-1){1'b0}}, tap_ff[0]});
   assign row_t   = y0_ff + $signed({{(COORD_BITS-1){1'b0}}, tap_ff[1]});
   assign rd_addr = {ch_ff, row_t[ROW_BITS-1:0], col_t[COL_BITS-1:0]};
   assign wx = tap_ff[0] ? {1'b0, fx_ff} : (FRACTION_BITS+1)'(ONE_FIX) - {1'b0, fx_ff};
   assign wy = tap_ff[1] ? {1'b0, fy_ff} : (FRACTION_BITS+1)'(ONE_FIX) - {1'b0, fy_ff};
   assign acc_sum = acc_ff + 32'(prod_ff);

   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      issue_vld_in  = 1'b0;
      issue_last_in = 1'b0;
      prod_vld_in   = issue_vld_ff;
      prod_last_in  = issue_last_ff;
      rsp_valid_in  = 1'b0;
      channels_in   = channels_ff;
      height_in     = height_ff;
      width_in      = width_ff;
      ch_in         = ch_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      weight_in     = WEIGHT_BITS'(wx) * WEIGHT_BITS'(wy);
      hit_in        = (COORD_BITS'(ch_ff) < COORD_BITS'(channels_ff))
                      && (COORD_BITS'(ch_ff) < COORD_BITS'(MAX_CHANNELS))
                      && in_bound(row_t, height_ff, MAX_HEIGHT)
                      && in_bound(col_t, width_ff, MAX_WIDTH);
      prod_in       = hit_ff ? PROD_BITS'($signed(rd_data_ff))
                               * PROD_BITS'($signed({1'b0, weight_ff}))
                             : '0;
      acc_in        = prod_vld_ff ? acc_sum : acc_ff;
      rsp_value_in  = rsp_value_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANNELS: channels_in = csr_wdata[5:0];
            CSR_HEIGHT:   height_in   = csr_wdata;
            CSR_WIDTH:    width_in    = csr_wdata;
            default:      ;
         endcase
      end

      if (prod_vld_ff && prod_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = acc_sum;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_SAMPLE)) begin
               state_in = ST_ISSUE;
               tap_in   = '0;
               ch_in    = req_channel;
               x0_in    = COORD_BITS'(req_sample_x >>> FRACTION_BITS);
               y0_in    = COORD_BITS'(req_sample_y >>> FRACTION_BITS);
               fx_in    = req_sample_x[FRACTION_BITS-1:0];
               fy_in    = req_sample_y[FRACTION_BITS-1:0];
               acc_in   = '0;
            end
         end
         ST_ISSUE: begin
            issue_vld_in = 1'b1;
            tap_in       = tap_ff + 2'd1;
            if (tap_ff == 2'd3) begin
               issue_last_in = 1'b1;
               state_in      = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // leave once the last product is folded into the result
            if (prod_vld_ff && prod_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_ff        <= '0;
         issue_vld_ff  <= 1'b0;
         issue_last_ff <= 1'b0;
         prod_vld_ff   <= 1'b0;
         prod_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         channels_ff   <= 6'd32;
         height_ff     <= 7'd64;
         width_ff      <= 7'd64;
      end else begin
         state_ff      <= state_in;
         tap_ff        <= tap_in;
         issue_vld_ff  <= issue_vld_in;
         issue_last_ff <= issue_last_in;
         prod_vld_ff   <= prod_vld_in;
         prod_last_ff  <= prod_last_in;
         rsp_valid_ff  <= rsp_valid_in;
         channels_ff   <= channels_in;
         height_ff     <= height_in;
         width_ff      <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      weight_ff    <= weight_in;
      hit_ff       <= hit_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_write_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;

   `ASSERT_NEXT(a_write_no_rsp, clock, reset, accept && (req_op == OP_WRITE), !rsp_valid)
   `ASSERT_NEXT(a_sample_busy, clock, reset, accept && (req_op == OP_SAMPLE), busy)
   `ASSERT_IMPLY(a_idle_empty, clock, reset, state_ff == ST_IDLE, !issue_vld_ff && !prod_vld_ff)
   `ASSERT_IMPLY(a_rsp_strobe, clock, reset, rsp_valid, !$past(rsp_valid))
   `ASSERT_IMPLY(a_no_write_busy, clock, reset, busy, !wr_en)

endmodule

/* tb/tb_top.sv */
module tb_top;
   import fmbs_pkg::*;

   // index with no register behind it; a write there must change nothing
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      op_type            op;
      logic [4:0]        channel;
      logic [5:0]        row;
      logic [5:0]        col;
      logic signed [15:0] value;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
   } sampler_cmd_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_op;
   logic [4:0]         req_channel;
   logic [5:0]         req_write_row;
   logic [5:0]         req_write_col;
   logic signed [15:0] req_write_value;
   logic signed [15:0] req_sample_x;
   logic signed [15:0] req_sample_y;
   logic               rsp_valid;
   logic signed [31:0] rsp_sample_value;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [6:0]         csr_wdata;

   feature_map_bilinear_sampler uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_channel      (req_channel),
      .req_write_row    (req_write_row),
      .req_write_col    (req_write_col),
      .req_write_value  (req_write_value),
      .req_sample_x     (req_sample_x),
      .req_sample_y     (req_sample_y),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // size registers as the block holds them
   int map_ch_reg = 32;
   int map_h_reg  = 64;
   int map_w_reg  = 64;

   logic [15:0] feature_mem [DEPTH];
   bit          gen_written [DEPTH];

   sampler_cmd_type         pending_cmds[$];
   logic signed [31:0]      expected_samples[$];
   sampler_cmd_type         cur_cmd;
   int                      sender_gap_pct = 0;
   int                      mismatches = 0;
   int                      samples_checked = 0;
   int                      writes_sent = 0;
   int                      size_settings = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int capped(int v, int lim);
      return (v < lim) ? v : lim;
   endfunction

   function automatic bit in_map(int ch, int row, int col);
      return ch < capped(map_ch_reg, MAX_CHANNELS) &&
             row >= 0 && row < capped(map_h_reg, MAX_HEIGHT) &&
             col >= 0 && col < capped(map_w_reg, MAX_WIDTH);
   endfunction

   function automatic int store_addr(int ch, int row, int col);
      return (ch * MAX_HEIGHT + row) * MAX_WIDTH + col;
   endfunction

   function automatic int pos_frac(logic signed [15:0] pos);
      return int'(pos) & (ONE_FIX - 1);
   endfunction

   function automatic int pos_floor(logic signed [15:0] pos);
      return (int'(pos) - pos_frac(pos)) / ONE_FIX;
   endfunction

   function automatic longint feature_tap(int ch, int row, int col);
      if (!in_map(ch, row, col)) return 0;
      return longint'($signed(feature_mem[store_addr(ch, row, col)]));
   endfunction

   function automatic logic signed [31:0] bilinear_sum(int ch, logic signed [15:0] sx,
                                                       logic signed [15:0] sy);
      int     fx;
      int     fy;
      int     x0;
      int     y0;
      longint acc;
      fx = pos_frac(sx);
      fy = pos_frac(sy);
      x0 = pos_floor(sx);
      y0 = pos_floor(sy);
      acc = longint'(ONE_FIX - fy) * longint'(ONE_FIX - fx) * feature_tap(ch, y0, x0)
          + longint'(ONE_FIX - fy) * longint'(fx) * feature_tap(ch, y0, x0 + 1)
          + longint'(fy) * longint'(ONE_FIX - fx) * feature_tap(ch, y0 + 1, x0)
          + longint'(fy) * longint'(fx) * feature_tap(ch, y0 + 1, x0 + 1);
      return acc[31:0];
   endfunction

   // Update the map copy or queue the expected sum for one accepted command.
   function automatic void track_command(sampler_cmd_type c);
      if (c.op == OP_WRITE) begin
         if (in_map(c.channel, c.row, c.col))
            feature_mem[store_addr(c.channel, c.row, c.col)] = c.value;
         writes_sent++;
      end else begin
         expected_samples.insert(expected_samples.size(), bilinear_sum(c.channel, c.sx, c.sy));
      end
   endfunction

   task automatic queue_write(int ch, int row, int col, logic [15:0] value);
      sampler_cmd_type c;
      c.op      = OP_WRITE;
      c.channel = ch[4:0];
      c.row     = row[5:0];
      c.col     = col[5:0];
      c.value   = value;
      c.sx      = 16'($urandom);
      c.sy      = 16'($urandom);
      pending_cmds.insert(pending_cmds.size(), c);
      if (in_map(ch, row, col)) gen_written[store_addr(ch, row, col)] = 1'b1;
   endtask

   // Load any in-map tap that was never written, then queue the sample.
   task automatic queue_sample(int ch, logic [15:0] sx, logic [15:0] sy);
      sampler_cmd_type c;
      int         r;
      int         k;
      for (int dy = 0; dy < 2; dy++) begin
         for (int dx = 0; dx < 2; dx++) begin
            r = pos_floor(sy) + dy;
            k = pos_floor(sx) + dx;
            if (in_map(ch, r, k) && !gen_written[store_addr(ch, r, k)])
               queue_write(ch, r, k, 16'($urandom));
         end
      end
      c.op      = OP_SAMPLE;
      c.channel = ch[4:0];
      c.row     = 6'($urandom);
      c.col     = 6'($urandom);
      c.value   = 16'($urandom);
      c.sx      = sx;
      c.sy      = sy;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   function automatic logic [15:0] rand_coord(int extent);
      int v;
      case ($urandom_range(9))
         0, 1: v = $urandom_range(65535);
         2: v = ($urandom_range(extent + 1) - 1) * ONE_FIX;
         3: v = $urandom_range(extent + 1) * ONE_FIX - 1;
         default: v = $urandom_range((extent + 2) * ONE_FIX - 1) - ONE_FIX;
      endcase
      return v[15:0];
   endfunction

   task automatic queue_random(int count);
      int bch;
      int bh;
      int bw;
      int ch;
      bch = capped(map_ch_reg, MAX_CHANNELS);
      bh  = capped(map_h_reg, MAX_HEIGHT);
      bw  = capped(map_w_reg, MAX_WIDTH);
      repeat (count) begin
         if ($urandom_range(4) == 0) ch = $urandom_range(31);
         else ch = $urandom_range((bch > 0) ? bch - 1 : 0);
         case ($urandom_range(9))
            0, 1, 2, 3, 4:
               queue_sample(ch, rand_coord(bw), rand_coord(bh));
            5, 6, 7:
               queue_write(ch, $urandom_range((bh > 0) ? bh - 1 : 0),
                           $urandom_range((bw > 0) ? bw - 1 : 0), 16'($urandom));
            default:
               queue_write($urandom_range(31), $urandom_range(63), $urandom_range(63),
                           16'($urandom));
         endcase
      end
   endtask

   // Return once no command is pending and every sample result has arrived.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_samples.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [6:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CHANNELS: map_ch_reg = value[5:0];
         CSR_HEIGHT:   map_h_reg  = value;
         CSR_WIDTH:    map_w_reg  = value;
         default: ;
      endcase
   endtask

   task automatic resize(logic [6:0] ch, logic [6:0] h, logic [6:0] w);
      write_csr(CSR_CHANNELS, ch);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_WIDTH, w);
      size_settings++;
   endtask

   // driver: one transfer per edge with start high and busy low
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) track_command(cur_cmd);
         if (start && busy) begin
            // hold the command until the block takes it
         end else if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
            cur_cmd = pending_cmds.pop_front();
            start           <= 1'b1;
            req_op          <= cur_cmd.op;
            req_channel     <= cur_cmd.channel;
            req_write_row   <= cur_cmd.row;
            req_write_col   <= cur_cmd.col;
            req_write_value <= cur_cmd.value;
            req_sample_x    <= cur_cmd.sx;
            req_sample_y    <= cur_cmd.sy;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: each strobe carries the next sample result in order
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample result, expected none, got %0d",
                     $time, rsp_sample_value);
            mismatches++;
         end else begin
            if (rsp_sample_value !== expected_samples[0]) begin
               $display("%0t: sample_value mismatch, expected %0d, got %0d",
                        $time, expected_samples[0], rsp_sample_value);
               mismatches++;
            end
            void'(expected_samples.pop_front());
            samples_checked++;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int k;
      reset           = 1'b1;
      start           = 1'b0;
      req_op          = 1'b0;
      req_channel     = '0;
      req_write_row   = '0;
      req_write_col   = '0;
      req_write_value = '0;
      req_sample_x    = '0;
      req_sample_y    = '0;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // most negative taps at full weight spread give the smallest sum
      queue_write(0, 0, 0, 16'h8000);
      queue_write(0, 0, 1, 16'h8000);
      queue_write(0, 1, 0, 16'h8000);
      queue_write(0, 1, 1, 16'h8000);
      queue_sample(0, 16'h0080, 16'h0080);
      queue_sample(0, 16'h0000, 16'h0000);
      queue_write(31, 63, 63, 16'h7fff);
      queue_sample(31, 16'h3fff, 16'h3fff);
      queue_sample(31, 16'h3f00, 16'h3f00);
      queue_sample(0, 16'hffff, 16'hffff);
      queue_sample(5, 16'h8000, 16'h7fff);
      queue_sample(0, 16'h0100, 16'h0000);
      queue_write(17, 42, 21, 16'h1234);
      queue_sample(17, 16'h1540, 16'h2a80);
      // hold off until the directed results are all back
      wait_idle();

      queue_random(150);
      wait_idle();

      // one channel bit six dropped, single-entry map
      resize(7'h41, 7'd1, 7'd1);
      sender_gap_pct = 81;
      queue_random(120);
      wait_idle();

      // no channels at all: every sample is zero
      resize(7'd0, 7'd2, 7'd64);
      write_csr(CSR_UNUSED, 7'h7f);
      sender_gap_pct = 0;
      queue_random(100);
      wait_idle();

      // registers beyond the maximum sizes
      resize(7'h3f, 7'd127, 7'd127);
      sender_gap_pct = 36;
      queue_random(180);
      wait_idle();

      resize(7'd7, 7'd5, 7'd9);
      sender_gap_pct = 81;
      queue_random(120);
      wait_idle();

      // zero rows
      resize(7'd5, 7'd0, 7'd7);
      sender_gap_pct = 0;
      queue_random(60);
      wait_idle();

      resize(7'd32, 7'd64, 7'd64);
      sender_gap_pct = 36;
      queue_random(80);

      for (k = 0; k < 20000 && (pending_cmds.size() != 0 || start ||
                                expected_samples.size() != 0); k++)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0) begin
         $display("%0t: %0d sample results never arrived, next expected %0d",
                  $time, expected_samples.size(), expected_samples[0]);
         mismatches += expected_samples.size();
      end
      $display("Checked %0d bilinear samples after %0d map writes", samples_checked,
               writes_sent);
      $display("Covered %0d map sizes incl. empty and over-limit, with idle sender gaps",
               size_settings);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/fmbs_pkg.sv
hw/rtl/feature_map_bilinear_sampler.sv
tb/tb_top.sv
